// ----- hdl/irdec_pkg.sv -----
// Shared protocol codes, classification windows and register indexes for the IR decoder.
`timescale 1ns / 1ps
`default_nettype none

package irdec_pkg;

    typedef enum logic [2:0] {
        PROTO_UNKNOWN = 3'd0,
        PROTO_RC5     = 3'd1,
        PROTO_RC6     = 3'd2,
        PROTO_SIRC    = 3'd3,
        PROTO_ERROR   = 3'd4
    } proto_t;

    // configuration register indexes
    localparam logic [2:0] CFG_RC5_SPLIT      = 3'd0;
    localparam logic [2:0] CFG_RC6_SPLIT      = 3'd1;
    localparam logic [2:0] CFG_RC6_WIDE_SPLIT = 3'd2;
    localparam logic [2:0] CFG_RC5_FRAME_BITS = 3'd3;
    localparam logic [2:0] CFG_RC6_FRAME_BITS = 3'd4;

    // register reset values
    localparam logic [7:0] RST_RC5_SPLIT      = 8'd63;
    localparam logic [7:0] RST_RC6_SPLIT      = 8'd30;
    localparam logic [7:0] RST_RC6_WIDE_SPLIT = 8'd53;
    localparam logic [7:0] RST_RC5_FRAME_BITS = 8'd12;
    localparam logic [7:0] RST_RC6_FRAME_BITS = 8'd21;

    // edge positions within a frame
    localparam logic [2:0] EDGE_LEAD     = 3'd2;
    localparam logic [2:0] EDGE_CLASSIFY = 3'd3;
    localparam logic [2:0] EDGE_DECODE   = 3'd4;
    localparam logic [2:0] EDGE_MAX      = 3'd7;

    // classification windows, inclusive
    localparam logic [7:0] WIN_SHORT_LO    = 8'd35;
    localparam logic [7:0] WIN_SHORT_HI    = 8'd50;
    localparam logic [7:0] WIN_RC5X_LO     = 8'd75;
    localparam logic [7:0] WIN_RC5X_HI     = 8'd95;
    localparam logic [7:0] WIN_RC6_LEAD_LO = 8'd105;
    localparam logic [7:0] WIN_RC6_LEAD_HI = 8'd145;
    localparam logic [7:0] WIN_SIRC_LO     = 8'd100;
    localparam logic [7:0] WIN_SIRC_HI     = 8'd130;
    localparam logic [7:0] WIN_SIRC_GAP_LO = 8'd21;
    localparam logic [7:0] WIN_SIRC_GAP_HI = 8'd33;

    // RC6 toggle bit positions
    localparam logic [7:0] RC6_TOGGLE_A = 8'd4;
    localparam logic [7:0] RC6_TOGGLE_B = 8'd5;

    localparam logic [15:0] CODE_BAD = 16'hffff;

endpackage

`default_nettype wire

// ----- hdl/ir_remote_edge_decoder.sv -----
// Top level of the IR remote edge decoder: input register, frame state, result register.
`timescale 1ns / 1ps
`default_nettype none

// IR remote edge decoder.
// Input channel (in_valid/in_ready): one beat per IR edge (action = 0) with the
// timer gap since the previous edge and the edge polarity, or a timeout beat
// (action = 1) that closes the frame. Edge beats produce no result; a timeout
// beat produces exactly one result beat on the output channel
// (out_valid/out_ready) carrying frame_valid, proto_id, code_word, bits_seen
// and toggle_bit, and then clears the frame state but for half_seen, toggle and lead gap.
// Timing: a beat is captured in the input register and processed in the
// next cycle (a few compares and one 16-bit shift), a timeout beat only once
// the output register is free, its result then going into that register. One beat per
// cycle is sustained; throughput is set only by the output register draining.
// Stalls: while a result waits in the output register, edge beats keep
// flowing; a timeout beat waits in the input register until the output
// register frees, and in_ready drops only then.
// Reset (rst_n low, asynchronous): frame state cleared, both registers empty,
// configuration registers back to 63/30/53/12/21.
// Configuration: cfg_write_en/cfg_index/cfg_data, to be written only while idle
// (the block itself does not enforce this); indexes above 4 are ignored.
module ir_remote_edge_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_write_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [7:0]  gap,
    input  wire logic        edge_level,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             frame_valid,
    output logic [2:0]       proto_id,
    output logic [15:0]      code_word,
    output logic [7:0]       bits_seen,
    output logic             toggle_bit
);

    // configuration registers
    logic [7:0] rc5_split_reg, rc6_split_reg, rc6_wide_split_reg;
    logic [7:0] rc5_frame_bits_reg, rc6_frame_bits_reg;

    // input register
    logic       in_full_reg;
    logic       act_reg;
    logic [7:0] gap_reg;
    logic       level_reg;

    // frame state
    logic [2:0]        edge_index_reg, edge_index_next;
    logic [7:0]        lead_gap_reg, lead_gap_next;
    irdec_pkg::proto_t proto_state_reg, proto_state_next;
    logic [15:0]       shift_code_reg, shift_code_next;
    logic [7:0]        bit_counter_reg, bit_counter_next;
    logic              half_seen_reg, half_seen_next;
    logic              count_ok_reg, count_ok_next;
    logic              toggle_store_reg, toggle_store_next;

    // result register
    logic              out_full_reg;
    logic              out_frame_valid_reg;
    irdec_pkg::proto_t out_proto_reg;
    logic [15:0]       out_code_reg;
    logic [7:0]        out_bits_reg;
    logic              out_toggle_reg;

    logic stage_fire;
    logic timeout_fire;
    logic out_free;

    assign out_free     = !out_full_reg || out_ready;
    assign stage_fire   = in_full_reg && (!act_reg || out_free);
    assign timeout_fire = stage_fire && act_reg;
    assign in_ready     = !in_full_reg || stage_fire;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc5_split_reg      <= irdec_pkg::RST_RC5_SPLIT;
            rc6_split_reg      <= irdec_pkg::RST_RC6_SPLIT;
            rc6_wide_split_reg <= irdec_pkg::RST_RC6_WIDE_SPLIT;
            rc5_frame_bits_reg <= irdec_pkg::RST_RC5_FRAME_BITS;
            rc6_frame_bits_reg <= irdec_pkg::RST_RC6_FRAME_BITS;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                irdec_pkg::CFG_RC5_SPLIT:      rc5_split_reg      <= cfg_data;
                irdec_pkg::CFG_RC6_SPLIT:      rc6_split_reg      <= cfg_data;
                irdec_pkg::CFG_RC6_WIDE_SPLIT: rc6_wide_split_reg <= cfg_data;
                irdec_pkg::CFG_RC5_FRAME_BITS: rc5_frame_bits_reg <= cfg_data;
                irdec_pkg::CFG_RC6_FRAME_BITS: rc6_frame_bits_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg   <= action;
            gap_reg   <= gap;
            level_reg <= edge_level;
        end
    end

    // ---------------- frame state update ----------------
    logic [2:0] edge_inc;
    logic [7:0] bc_plus;
    logic       lead_short, lead_rc5x, lead_rc6, lead_sirc;
    logic       gap_short, gap_rc5x, gap_sirc;
    logic       man_short, man_bit;
    logic [7:0] man_frame_bits;
    logic [7:0] rc6_split_sel;

    always_comb
    begin
        edge_inc = (edge_index_reg != irdec_pkg::EDGE_MAX) ? edge_index_reg + 3'd1
                                                           : edge_index_reg;
        bc_plus  = bit_counter_reg + 8'd1;

        lead_short = lead_gap_reg >= irdec_pkg::WIN_SHORT_LO
                  && lead_gap_reg <= irdec_pkg::WIN_SHORT_HI;
        lead_rc5x  = lead_gap_reg >= irdec_pkg::WIN_RC5X_LO
                  && lead_gap_reg <= irdec_pkg::WIN_RC5X_HI;
        lead_rc6   = lead_gap_reg >= irdec_pkg::WIN_RC6_LEAD_LO
                  && lead_gap_reg <= irdec_pkg::WIN_RC6_LEAD_HI;
        lead_sirc  = lead_gap_reg >= irdec_pkg::WIN_SIRC_LO
                  && lead_gap_reg <= irdec_pkg::WIN_SIRC_HI;
        gap_short  = gap_reg >= irdec_pkg::WIN_SHORT_LO && gap_reg <= irdec_pkg::WIN_SHORT_HI;
        gap_rc5x   = gap_reg >= irdec_pkg::WIN_SHORT_LO && gap_reg <= irdec_pkg::WIN_RC5X_HI;
        gap_sirc   = gap_reg >= irdec_pkg::WIN_SIRC_GAP_LO
                  && gap_reg <= irdec_pkg::WIN_SIRC_GAP_HI;

        // RC6 toggle bits use the wider split
        rc6_split_sel = (bit_counter_reg == irdec_pkg::RC6_TOGGLE_A
                      || bit_counter_reg == irdec_pkg::RC6_TOGGLE_B)
                      ? rc6_wide_split_reg : rc6_split_reg;

        // RC5 bits are inverted relative to the edge polarity
        if (proto_state_reg == irdec_pkg::PROTO_RC5)
        begin
            man_short      = gap_reg < rc5_split_reg;
            man_bit        = !level_reg;
            man_frame_bits = rc5_frame_bits_reg;
        end
        else
        begin
            man_short      = gap_reg < rc6_split_sel;
            man_bit        = level_reg;
            man_frame_bits = rc6_frame_bits_reg;
        end

        edge_index_next   = edge_index_reg;
        lead_gap_next     = lead_gap_reg;
        proto_state_next  = proto_state_reg;
        shift_code_next   = shift_code_reg;
        bit_counter_next  = bit_counter_reg;
        half_seen_next    = half_seen_reg;
        count_ok_next     = count_ok_reg;
        toggle_store_next = toggle_store_reg;

        if (stage_fire)
        begin
            if (act_reg)
            begin
                // timeout closes the frame; half_seen, toggle and lead gap persist
                shift_code_next  = '0;
                bit_counter_next = '0;
                edge_index_next  = '0;
                count_ok_next    = 1'b0;
                proto_state_next = irdec_pkg::PROTO_UNKNOWN;
            end
            else
            begin
                edge_index_next = edge_inc;
                if (edge_inc == irdec_pkg::EDGE_LEAD)
                begin
                    lead_gap_next = gap_reg;
                end
                else if (edge_inc == irdec_pkg::EDGE_CLASSIFY)
                begin
                    if (lead_short && gap_short)
                    begin
                        proto_state_next = irdec_pkg::PROTO_RC5;
                        half_seen_next   = 1'b0;
                    end
                    else if (lead_rc5x && gap_rc5x)
                    begin
                        proto_state_next = irdec_pkg::PROTO_RC5;
                        if (gap_reg < rc5_split_reg)
                        begin
                            half_seen_next  = 1'b1;
                            shift_code_next = 16'd1;
                        end
                        else
                        begin
                            half_seen_next   = 1'b0;
                            bit_counter_next = 8'd1;
                            shift_code_next  = 16'd3;
                        end
                    end
                    else if (lead_rc6 && gap_short)
                    begin
                        proto_state_next = irdec_pkg::PROTO_RC6;
                        half_seen_next   = 1'b1;
                    end
                    else if (lead_sirc && gap_sirc)
                    begin
                        proto_state_next = irdec_pkg::PROTO_SIRC;
                    end
                    else
                    begin
                        proto_state_next = irdec_pkg::PROTO_UNKNOWN;
                    end
                end
                else if (edge_inc >= irdec_pkg::EDGE_DECODE)
                begin
                    if (proto_state_reg == irdec_pkg::PROTO_RC5
                        || proto_state_reg == irdec_pkg::PROTO_RC6)
                    begin
                        // Manchester step
                        if (half_seen_reg == man_short)
                        begin
                            half_seen_next   = 1'b0;
                            bit_counter_next = bc_plus;
                            shift_code_next  = {shift_code_reg[14:0], man_bit};
                            count_ok_next    = bc_plus == man_frame_bits;
                            if (proto_state_reg == irdec_pkg::PROTO_RC6
                                && bc_plus == irdec_pkg::RC6_TOGGLE_B)
                            begin
                                toggle_store_next = man_bit;
                            end
                        end
                        else if (!half_seen_reg && man_short)
                        begin
                            half_seen_next = 1'b1;
                        end
                        else
                        begin
                            proto_state_next = irdec_pkg::PROTO_ERROR;
                        end
                    end
                    else
                    begin
                        shift_code_next = irdec_pkg::CODE_BAD;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_index_reg   <= '0;
            lead_gap_reg     <= '0;
            proto_state_reg  <= irdec_pkg::PROTO_UNKNOWN;
            shift_code_reg   <= '0;
            bit_counter_reg  <= '0;
            half_seen_reg    <= 1'b0;
            count_ok_reg     <= 1'b0;
            toggle_store_reg <= 1'b0;
        end
        else
        begin
            edge_index_reg   <= edge_index_next;
            lead_gap_reg     <= lead_gap_next;
            proto_state_reg  <= proto_state_next;
            shift_code_reg   <= shift_code_next;
            bit_counter_reg  <= bit_counter_next;
            half_seen_reg    <= half_seen_next;
            count_ok_reg     <= count_ok_next;
            toggle_store_reg <= toggle_store_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (timeout_fire)
        begin
            out_full_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (timeout_fire)
        begin
            out_frame_valid_reg <= count_ok_reg
                                && proto_state_reg != irdec_pkg::PROTO_ERROR
                                && proto_state_reg != irdec_pkg::PROTO_UNKNOWN;
            out_proto_reg       <= proto_state_reg;
            out_code_reg        <= shift_code_reg;
            out_bits_reg        <= bit_counter_reg;
            out_toggle_reg      <= toggle_store_reg;
        end
    end

    assign out_valid   = out_full_reg;
    assign frame_valid = out_frame_valid_reg;
    assign proto_id    = out_proto_reg;
    assign code_word   = out_code_reg;
    assign bits_seen   = out_bits_reg;
    assign toggle_bit  = out_toggle_reg;

    // ---------------- assertions ----------------
    // a new result only ever comes from a timeout beat
    a_result_from_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_full_reg) |-> $past(timeout_fire))
        else $error("result beat without a timeout");

    // a timeout leaves a clean frame
    a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
        timeout_fire |=> (edge_index_reg == '0 && bit_counter_reg == '0
                          && proto_state_reg == irdec_pkg::PROTO_UNKNOWN))
        else $error("frame state not cleared by timeout");

    // a waiting beat in the input register is never lost
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && !stage_fire) |=> (in_full_reg && $stable(gap_reg)
                                          && $stable(act_reg)))
        else $error("input register overwritten");

    // a valid frame is always RC5 or RC6
    a_valid_proto: assert property (@(posedge clk) disable iff (!rst_n)
        (out_full_reg && out_frame_valid_reg) |->
            (out_proto_reg == irdec_pkg::PROTO_RC5 || out_proto_reg == irdec_pkg::PROTO_RC6))
        else $error("frame_valid on a non-Manchester protocol");

endmodule

`default_nettype wire

// ----- test/tb_ir_remote_edge_decoder.sv -----
// Testbench for the IR remote edge decoder: frame scoreboard, beat drivers and checks.
`timescale 1ns / 1ps

module tb_ir_remote_edge_decoder;

    // action field codes
    localparam bit ACT_EDGE    = 1'b0;
    localparam bit ACT_TIMEOUT = 1'b1;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;     // pipeline is two registers deep
    localparam int LONG_HOLD     = 300;   // receiver hold-off for the back-pressure phase

    typedef enum int {FRAME_RC5, FRAME_RC5X, FRAME_RC6, FRAME_SIRC, FRAME_NOISE} frame_kind_t;

    typedef struct packed {
        logic              valid;
        irdec_pkg::proto_t proto;
        logic [15:0]       code;
        logic [7:0]        bits;
        logic              toggle;
    } frame_report_t;

    // Frame tracker: mirrors the decoder state on every accepted input beat and
    // queues the report a timeout beat must produce.
    class ir_frame_scoreboard;
        logic [7:0]        rc5_split, rc6_split, rc6_wide_split, rc5_frame_bits, rc6_frame_bits;
        logic [2:0]        edge_count;
        logic [7:0]        lead_gap;
        irdec_pkg::proto_t proto;
        logic [15:0]       code;
        logic [7:0]        bits;
        bit                half, count_ok, toggle;
        frame_report_t     pending_reports[$];
        int                errors;

        function new();
            rc5_split      = irdec_pkg::RST_RC5_SPLIT;
            rc6_split      = irdec_pkg::RST_RC6_SPLIT;
            rc6_wide_split = irdec_pkg::RST_RC6_WIDE_SPLIT;
            rc5_frame_bits = irdec_pkg::RST_RC5_FRAME_BITS;
            rc6_frame_bits = irdec_pkg::RST_RC6_FRAME_BITS;
            edge_count = '0;
            lead_gap   = '0;
            proto      = irdec_pkg::PROTO_UNKNOWN;
            code       = '0;
            bits       = '0;
            half       = 1'b0;
            count_ok   = 1'b0;
            toggle     = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                irdec_pkg::CFG_RC5_SPLIT:      rc5_split = val;
                irdec_pkg::CFG_RC6_SPLIT:      rc6_split = val;
                irdec_pkg::CFG_RC6_WIDE_SPLIT: rc6_wide_split = val;
                irdec_pkg::CFG_RC5_FRAME_BITS: rc5_frame_bits = val;
                irdec_pkg::CFG_RC6_FRAME_BITS: rc6_frame_bits = val;
                default: ;
            endcase
        endfunction

        // half/full split in force for the next decoded gap
        function logic [7:0] decode_split();
            if (proto == irdec_pkg::PROTO_RC6)
                return (bits == irdec_pkg::RC6_TOGGLE_A || bits == irdec_pkg::RC6_TOGGLE_B)
                       ? rc6_wide_split : rc6_split;
            return rc5_split;
        endfunction

        function bit in_win(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
            return v >= lo && v <= hi;
        endfunction

        function void classify(logic [7:0] g);
            if (in_win(lead_gap, irdec_pkg::WIN_SHORT_LO, irdec_pkg::WIN_SHORT_HI)
                && in_win(g, irdec_pkg::WIN_SHORT_LO, irdec_pkg::WIN_SHORT_HI))
            begin
                proto = irdec_pkg::PROTO_RC5;
                half  = 1'b0;
            end
            else if (in_win(lead_gap, irdec_pkg::WIN_RC5X_LO, irdec_pkg::WIN_RC5X_HI)
                     && in_win(g, irdec_pkg::WIN_SHORT_LO, irdec_pkg::WIN_RC5X_HI))
            begin
                proto = irdec_pkg::PROTO_RC5;
                code  = 16'd1;
                half  = g < rc5_split;
                if (!half)
                begin
                    bits = 8'd1;
                    code = 16'd3;
                end
            end
            else if (in_win(lead_gap, irdec_pkg::WIN_RC6_LEAD_LO, irdec_pkg::WIN_RC6_LEAD_HI)
                     && in_win(g, irdec_pkg::WIN_SHORT_LO, irdec_pkg::WIN_SHORT_HI))
            begin
                proto = irdec_pkg::PROTO_RC6;
                half  = 1'b1;
            end
            else if (in_win(lead_gap, irdec_pkg::WIN_SIRC_LO, irdec_pkg::WIN_SIRC_HI)
                     && in_win(g, irdec_pkg::WIN_SIRC_GAP_LO, irdec_pkg::WIN_SIRC_GAP_HI))
                proto = irdec_pkg::PROTO_SIRC;
            else
                proto = irdec_pkg::PROTO_UNKNOWN;
        endfunction

        // one Manchester half step; 1 when a bit was shifted in
        function bit manchester_step(bit short_gap, bit value, logic [7:0] frame_bits);
            if (half == short_gap)
            begin
                half     = 1'b0;
                bits     = bits + 8'd1;
                code     = {code[14:0], value};
                count_ok = (bits == frame_bits);
                return 1'b1;
            end
            if (!half && short_gap)
                half = 1'b1;
            else
                proto = irdec_pkg::PROTO_ERROR;
            return 1'b0;
        endfunction

        function void decode_edge(logic [7:0] g, bit rising);
            logic [7:0] split;
            split = decode_split();
            if (proto == irdec_pkg::PROTO_RC5)
                void'(manchester_step(g < split, !rising, rc5_frame_bits));
            else if (proto == irdec_pkg::PROTO_RC6)
            begin
                if (manchester_step(g < split, rising, rc6_frame_bits)
                    && bits == irdec_pkg::RC6_TOGGLE_B)
                    toggle = code[0];
            end
            else
                code = irdec_pkg::CODE_BAD;
        endfunction

        function void note_beat(bit act, logic [7:0] g, bit lvl);
            frame_report_t rep;
            if (act == ACT_TIMEOUT)
            begin
                rep.valid  = proto != irdec_pkg::PROTO_ERROR
                          && proto != irdec_pkg::PROTO_UNKNOWN && count_ok;
                rep.proto  = proto;
                rep.code   = code;
                rep.bits   = bits;
                rep.toggle = toggle;
                pending_reports.push_back(rep);
                // half, toggle and lead gap survive the timeout
                code       = '0;
                bits       = '0;
                edge_count = '0;
                count_ok   = 1'b0;
                proto      = irdec_pkg::PROTO_UNKNOWN;
                return;
            end
            if (edge_count < irdec_pkg::EDGE_MAX)
                edge_count = edge_count + 3'd1;
            if (edge_count == irdec_pkg::EDGE_LEAD)
                lead_gap = g;
            else if (edge_count == irdec_pkg::EDGE_CLASSIFY)
                classify(g);
            else if (edge_count >= irdec_pkg::EDGE_DECODE)
                decode_edge(g, lvl);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic fv, logic [2:0] pid, logic [15:0] cw,
                                   logic [7:0] bs, logic tb);
            frame_report_t want;
            if (pending_reports.size() == 0)
            begin
                $error("result beat with no report pending: proto_id %0d code_word %h", pid, cw);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("frame_valid", want.valid, fv);
            compare_field("proto_id", want.proto, pid);
            compare_field("code_word", want.code, cw);
            compare_field("bits_seen", want.bits, bs);
            compare_field("toggle_bit", want.toggle, tb);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [7:0]  gap;
    logic        edge_level;
    logic        out_valid;
    logic        out_ready;
    logic        frame_valid;
    logic [2:0]  proto_id;
    logic [15:0] code_word;
    logic [7:0]  bits_seen;
    logic        toggle_bit;

    ir_frame_scoreboard sb;
    int beats_sent;
    int cycle_count;
    bit idle_enable;     // random idling on both channels
    bit hold_request;    // asks the receiver for one long hold-off

    ir_remote_edge_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .gap          (gap),
        .edge_level   (edge_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_valid  (frame_valid),
        .proto_id     (proto_id),
        .code_word    (code_word),
        .bits_seen    (bits_seen),
        .toggle_bit   (toggle_bit)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle watchdog: only a hung run gets here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold-off on request so the
    // output register stays full and a following timeout beat backs up the input.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Result monitor: values read at the edge are the ones the edge sees.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_report(frame_valid, proto_id, code_word, bits_seen, toggle_bit);
    end

    // One input beat, optionally after an idle burst; returns once accepted.
    task automatic send_beat(bit act, logic [7:0] g, bit lvl);
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        gap        <= g;
        edge_level <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_beat(act, g, lvl);
        beats_sent++;
    endtask

    task automatic write_one(logic [2:0] idx, logic [7:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // Writes all five registers; optionally pokes the unused indexes too.
    task automatic program_regs(logic [7:0] r5, logic [7:0] r6, logic [7:0] r6w,
                                logic [7:0] b5, logic [7:0] b6, bit with_unused);
        write_one(irdec_pkg::CFG_RC5_SPLIT, r5);
        write_one(irdec_pkg::CFG_RC6_SPLIT, r6);
        write_one(irdec_pkg::CFG_RC6_WIDE_SPLIT, r6w);
        write_one(irdec_pkg::CFG_RC5_FRAME_BITS, b5);
        write_one(irdec_pkg::CFG_RC6_FRAME_BITS, b6);
        if (with_unused)
            for (int k = irdec_pkg::CFG_RC6_FRAME_BITS + 1; k <= 7; k++)
                write_one(3'(k), 8'($urandom_range(0, 255)));
        cfg_write_en <= 1'b0;
    endtask

    // Ends a phase with a timeout, then lets the decoder go fully idle.
    task automatic close_phase();
        send_beat(ACT_TIMEOUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        in_valid <= 1'b0;
        while (sb.pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Gap on the requested side of the split, boundary values now and then.
    function automatic logic [7:0] pick_gap(bit want_short, logic [7:0] split);
        if (want_short && split != 8'd0)
            return ($urandom_range(0, 3) == 0) ? split - 8'd1 : 8'($urandom_range(0, split - 1));
        return ($urandom_range(0, 3) == 0) ? split : 8'($urandom_range(split, 255));
    endfunction

    // One frame: a free first edge, lead and classify gaps picked for the kind,
    // then Manchester gaps steered by the tracked half-bit state, then timeout.
    task automatic send_frame(frame_kind_t kind);
        logic [7:0] lead, cls, g;
        int target, edges_left;
        bit want_short;
        case (kind)
            FRAME_RC5:
            begin
                lead = 8'($urandom_range(irdec_pkg::WIN_SHORT_LO, irdec_pkg::WIN_SHORT_HI));
                cls  = 8'($urandom_range(irdec_pkg::WIN_SHORT_LO, irdec_pkg::WIN_SHORT_HI));
            end
            FRAME_RC5X:
            begin
                lead = 8'($urandom_range(irdec_pkg::WIN_RC5X_LO, irdec_pkg::WIN_RC5X_HI));
                cls  = 8'($urandom_range(irdec_pkg::WIN_SHORT_LO, irdec_pkg::WIN_RC5X_HI));
            end
            FRAME_RC6:
            begin
                lead = 8'($urandom_range(irdec_pkg::WIN_RC6_LEAD_LO,
                                         irdec_pkg::WIN_RC6_LEAD_HI));
                cls  = 8'($urandom_range(irdec_pkg::WIN_SHORT_LO, irdec_pkg::WIN_SHORT_HI));
            end
            FRAME_SIRC:
            begin
                lead = 8'($urandom_range(irdec_pkg::WIN_SIRC_LO, irdec_pkg::WIN_SIRC_HI));
                cls  = 8'($urandom_range(irdec_pkg::WIN_SIRC_GAP_LO,
                                         irdec_pkg::WIN_SIRC_GAP_HI));
            end
            default:
            begin
                lead = 8'($urandom_range(0, 255));
                cls  = 8'($urandom_range(0, 255));
            end
        endcase
        send_beat(ACT_EDGE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_beat(ACT_EDGE, lead, 1'($urandom_range(0, 1)));
        send_beat(ACT_EDGE, cls, 1'($urandom_range(0, 1)));

        // aim for a complete frame most of the time
        target = $urandom_range(0, 40);
        if ($urandom_range(0, 9) < 6)
        begin
            if (sb.proto == irdec_pkg::PROTO_RC6 && sb.rc6_frame_bits <= 40)
                target = sb.rc6_frame_bits;
            else if (sb.proto == irdec_pkg::PROTO_RC5 && sb.rc5_frame_bits <= 40)
                target = sb.rc5_frame_bits;
        end
        edges_left = (kind <= FRAME_RC6) ? 2 * target + 4 : $urandom_range(0, 12);
        if ($urandom_range(0, 7) == 0)
            edges_left = $urandom_range(0, 6);

        while (edges_left > 0)
        begin
            if (sb.proto == irdec_pkg::PROTO_RC5 || sb.proto == irdec_pkg::PROTO_RC6)
            begin
                if (sb.bits == target)
                    break;
                // after a half bit a full gap is a Manchester violation, kept rare
                want_short = sb.half ? ($urandom_range(0, 19) != 0) : 1'($urandom_range(0, 1));
                g = pick_gap(want_short, sb.decode_split());
            end
            else
                g = 8'($urandom_range(0, 255));
            send_beat(ACT_EDGE, g, 1'($urandom_range(0, 1)));
            edges_left--;
        end
        send_beat(ACT_TIMEOUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_random(int quota);
        int stop_at;
        int roll;
        stop_at = beats_sent + quota;
        while (beats_sent < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 28)
                send_frame(FRAME_RC5);
            else if (roll < 42)
                send_frame(FRAME_RC5X);
            else if (roll < 72)
                send_frame(FRAME_RC6);
            else if (roll < 80)
                send_frame(FRAME_SIRC);
            else if (roll < 90)
                send_frame(FRAME_NOISE);
            else
                send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    // Directed beats: field extremes, the short-lead RC5, RC6 and SIRC windows, a violation,
    // and a timeout with nothing received.
    task automatic run_directed();
        send_beat(ACT_TIMEOUT, 8'hff, 1'b1);
        // short lead: rc5, full/half bits at gap extremes, then a violation
        send_beat(ACT_EDGE, 8'h00, 1'b0);
        send_beat(ACT_EDGE, irdec_pkg::WIN_SHORT_LO, 1'b1);
        send_beat(ACT_EDGE, irdec_pkg::WIN_SHORT_HI, 1'b0);
        send_beat(ACT_EDGE, 8'hff, 1'b1);
        send_beat(ACT_EDGE, 8'h00, 1'b0);
        send_beat(ACT_EDGE, 8'h00, 1'b1);
        send_beat(ACT_EDGE, 8'h00, 1'b0);
        send_beat(ACT_EDGE, 8'hff, 1'b0);
        send_beat(ACT_TIMEOUT, 8'h00, 1'b0);
        // rc6 lead at the top of its window
        send_beat(ACT_EDGE, 8'h00, 1'b1);
        send_beat(ACT_EDGE, irdec_pkg::WIN_RC6_LEAD_HI, 1'b0);
        send_beat(ACT_EDGE, irdec_pkg::WIN_SHORT_LO, 1'b1);
        send_beat(ACT_EDGE, 8'h00, 1'b1);
        send_beat(ACT_EDGE, 8'h00, 1'b0);
        send_beat(ACT_TIMEOUT, 8'hff, 1'b0);
        // sirc lead: later edges only poison the code
        send_beat(ACT_EDGE, 8'hff, 1'b0);
        send_beat(ACT_EDGE, irdec_pkg::WIN_SIRC_LO, 1'b1);
        send_beat(ACT_EDGE, irdec_pkg::WIN_SIRC_GAP_LO, 1'b0);
        send_beat(ACT_EDGE, irdec_pkg::WIN_SIRC_GAP_HI, 1'b1);
        send_beat(ACT_TIMEOUT, 8'h00, 1'b1);
        // no window matches
        send_beat(ACT_EDGE, 8'h00, 1'b0);
        send_beat(ACT_EDGE, 8'hff, 1'b1);
        send_beat(ACT_EDGE, 8'h00, 1'b1);
        send_beat(ACT_TIMEOUT, 8'h00, 1'b0);
    endtask

    // rc5 frame of only full bits, long enough for the bit counter to wrap
    task automatic send_wrap_frame();
        send_beat(ACT_EDGE, 8'($urandom_range(0, 255)), 1'b0);
        send_beat(ACT_EDGE, irdec_pkg::WIN_SHORT_LO, 1'b1);
        send_beat(ACT_EDGE, irdec_pkg::WIN_SHORT_HI, 1'b0);
        repeat (300)
            send_beat(ACT_EDGE, pick_gap(1'b0, sb.rc5_split), 1'($urandom_range(0, 1)));
        send_beat(ACT_TIMEOUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= irdec_pkg::CFG_RC5_SPLIT;
        cfg_data     <= irdec_pkg::RST_RC5_SPLIT;
        in_valid     <= 1'b0;
        action       <= ACT_EDGE;
        gap          <= 8'h00;
        edge_level   <= 1'b0;
        sb           = new();
        beats_sent   = 0;
        idle_enable  = 1'b1;
        hold_request = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values
        run_directed();
        send_wrap_frame();
        run_random(300);
        close_phase();

        // all registers at the bottom, then at the top
        program_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        run_random(150);
        close_phase();
        program_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        run_random(150);
        close_phase();

        // fully random values, with writes to the unused indexes
        program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 1'b1);
        run_random(120);
        close_phase();

        // plausible timing splits with short frames
        repeat (3)
        begin
            program_regs(8'($urandom_range(20, 120)), 8'($urandom_range(10, 80)),
                         8'($urandom_range(20, 120)), 8'($urandom_range(0, 30)),
                         8'($urandom_range(0, 30)), 1'b0);
            run_random(120);
            close_phase();
        end

        // back pressure: timeouts keep coming while the receiver holds off
        program_regs(irdec_pkg::RST_RC5_SPLIT, irdec_pkg::RST_RC6_SPLIT,
                     irdec_pkg::RST_RC6_WIDE_SPLIT, irdec_pkg::RST_RC5_FRAME_BITS,
                     irdec_pkg::RST_RC6_FRAME_BITS, 1'b0);
        hold_request = 1'b1;
        repeat (30)
        begin
            send_beat(ACT_EDGE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            send_beat(ACT_TIMEOUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        close_phase();

        // last stretch at full rate on both sides
        idle_enable = 1'b0;
        run_random(200);
        close_phase();

        if (sb.errors == 0 && sb.pending_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
